// ===== design/brs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the balance robot supervisor
// used by brs_ctrl, brs_datapath and the top level; no dependencies
package brs_pkg;

  // supervisor modes
  localparam logic [2:0] MODE_WAIT    = 3'd0;
  localparam logic [2:0] MODE_CALIB   = 3'd1;
  localparam logic [2:0] MODE_READY   = 3'd2;
  localparam logic [2:0] MODE_BALANCE = 3'd3;
  localparam logic [2:0] MODE_FALLEN  = 3'd4;

  // pid commands
  localparam logic [1:0] PCMD_NONE = 2'd0;
  localparam logic [1:0] PCMD_RUN  = 2'd1;
  localparam logic [1:0] PCMD_OFF  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TILT_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_CALIB_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MISSING_LIMIT = 2'd2;
  localparam logic [1:0] CFG_TICK_MS       = 2'd3;

  // configuration reset values
  localparam logic [14:0] TILT_LIMIT_RST    = 15'd7680;
  localparam logic [15:0] CALIB_TIMEOUT_RST = 16'd10000;
  localparam logic [7:0]  MISSING_LIMIT_RST = 8'd10;
  localparam logic [7:0]  TICK_MS_RST       = 8'd4;

  // beep phases and lengths
  localparam logic [3:0] PHASE_CALIB_END = 4'd5;
  localparam logic [3:0] PHASE_ERROR     = 4'd10;
  localparam logic [7:0] BEEP_LONG       = 8'd100;
  localparam logic [7:0] BEEP_SHORT      = 8'd50;

  // timing in ms
  localparam int CALIB_BEEP_GAP = 400;
  localparam int READY_GAP_1    = 200;
  localparam int READY_GAP_2    = 500;
  localparam logic [10:0] PAT_PERIOD = 11'd1000;
  localparam logic [9:0]  PAT_BEEP_0 = 10'd0;
  localparam logic [9:0]  PAT_BEEP_1 = 10'd100;
  localparam logic [9:0]  PAT_BEEP_2 = 10'd200;

  // motor mapping: x = 5500*256*256 / (|p| + 9*256), speed = 400 - (405*256 - x)/256
  localparam int DIV_BITS  = 29;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);
  localparam logic [DIV_BITS-1:0] MAP_NUMER  = 29'd360448000;
  localparam logic [23:0]         MAP_OFFSET = 24'd2304;
  localparam logic signed [18:0]  MAP_BASE   = 19'sd103680;
  localparam logic signed [11:0]  SPEED_TOP  = 12'sd400;

  // stream widths
  localparam int IN_W  = 48;
  localparam int OUT_W = 32;
  localparam int CFG_W = 16;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch input beat, advance clocks, seed divider
    logic step;    // one divider iteration
    logic commit;  // update supervisor state and load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } stat_t;

endpackage

// ===== design/brs_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing controller: accept, run the divider, commit the tick
// depends on brs_pkg
module brs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  brs_pkg::stat_t stat,
  output brs_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                    state, state_next;
  logic [brs_pkg::DIV_CNT_W-1:0] cnt, cnt_next;
  logic                          last_step;

  assign last_step = (cnt == brs_pkg::DIV_CNT_W'(brs_pkg::DIV_BITS - 1));

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== design/brs_datapath.sv =====
`timescale 1ns / 1ps
// supervisor datapath: config registers, timers, mode logic, serial divider
// for the motor mapping and the result register; depends on brs_pkg
module brs_datapath #(
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  brs_pkg::cmd_t            cmd,
  output brs_pkg::stat_t           stat,
  input  logic [brs_pkg::IN_W-1:0] in_data,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [brs_pkg::CFG_W-1:0] cfg_data,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [brs_pkg::OUT_W-1:0] m_tdata
);

  // configuration
  logic [14:0] tilt_limit;
  logic [15:0] calib_limit;
  logic [7:0]  missing_limit;
  logic [7:0]  tick_ms;

  // supervisor state
  logic [2:0]           current_mode;
  logic [TIME_BITS-1:0] clock_ms, mode_start_ms, beep_mark_ms;
  logic [3:0]           beep_phase;
  logic [7:0]           missed_count;
  logic [9:0]           error_pattern_ms;

  // latched input beat
  logic               got, btn, busy;
  logic signed [15:0] tilt;
  logic signed [23:0] pid;

  // divider
  logic [brs_pkg::DIV_BITS-1:0] quo;
  logic [23:0]                  rem, divisor;
  logic [24:0]                  rem_sh;
  logic                         rem_ge;

  // result register fields
  logic [2:0]         o_mode;
  logic               o_mw, o_beep, o_cb, o_cc;
  logic signed [10:0] o_speed;
  logic [1:0]         o_pcmd;
  logic [7:0]         o_blen;

  // commit values
  logic [2:0]           mode_n;
  logic [TIME_BITS-1:0] start_n, mark_n;
  logic [3:0]           phase_n;
  logic [7:0]           miss_n;
  logic [9:0]           pat_n;
  logic                 mw_n, beep_n, cb_n, cc_n;
  logic signed [10:0]   speed_n;
  logic [1:0]           pcmd_n;
  logic [7:0]           blen_n;

  logic [TIME_BITS-1:0] since_mark, since_start;
  logic [10:0]          pat_sum;
  logic signed [16:0]   tilt_x, lim_x;
  logic                 tilt_out;
  logic signed [18:0]   map_c;
  logic [18:0]          map_cmag;
  logic signed [11:0]   map_ci, map_sp;
  logic signed [10:0]   map_speed;

  assign stat.out_free = !m_tvalid || m_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_limit    <= brs_pkg::TILT_LIMIT_RST;
      calib_limit   <= brs_pkg::CALIB_TIMEOUT_RST;
      missing_limit <= brs_pkg::MISSING_LIMIT_RST;
      tick_ms       <= brs_pkg::TICK_MS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        brs_pkg::CFG_TILT_LIMIT:    tilt_limit    <= cfg_data[14:0];
        brs_pkg::CFG_CALIB_TIMEOUT: calib_limit   <= cfg_data;
        brs_pkg::CFG_MISSING_LIMIT: missing_limit <= cfg_data[7:0];
        brs_pkg::CFG_TICK_MS:       tick_ms       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // divider step: shift in one dividend bit, subtract when it fits
  assign rem_sh  = {rem, quo[brs_pkg::DIV_BITS-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};

  // motor mapping from the quotient, truncating toward zero
  assign map_c     = brs_pkg::MAP_BASE - $signed({1'b0, quo[17:0]});
  assign map_cmag  = map_c[18] ? 19'(-map_c) : 19'(map_c);
  assign map_ci    = map_c[18] ? -$signed({1'b0, map_cmag[18:8]})
                               : $signed({1'b0, map_cmag[18:8]});
  assign map_sp    = brs_pkg::SPEED_TOP - map_ci;
  assign map_speed = (pid == '0) ? 11'sd0 :
                     pid[23] ? 11'(-map_sp) : 11'(map_sp);

  // pattern counter advance, wraps at 1000
  assign pat_sum = {1'b0, error_pattern_ms} + {3'b000, tick_ms};

  // tilt check against the signed limit
  assign tilt_x   = {tilt[15], tilt};
  assign lim_x    = $signed({2'b00, tilt_limit});
  assign tilt_out = (tilt_x > lim_x) || (tilt_x < -lim_x);

  assign since_mark  = clock_ms - beep_mark_ms;
  assign since_start = clock_ms - mode_start_ms;

  // supervisor decision for the current tick
  always_comb begin
    mode_n  = current_mode;
    start_n = mode_start_ms;
    mark_n  = beep_mark_ms;
    phase_n = beep_phase;
    miss_n  = missed_count;
    pat_n   = error_pattern_ms;
    mw_n    = 1'b0;
    speed_n = 11'sd0;
    pcmd_n  = brs_pkg::PCMD_NONE;
    beep_n  = 1'b0;
    blen_n  = 8'd0;
    cb_n    = 1'b0;
    cc_n    = 1'b0;

    // missed samples
    if (!got) begin
      if (miss_n != 8'hFF) begin
        miss_n = miss_n + 8'd1;
      end
      if (miss_n >= missing_limit && mode_n != brs_pkg::MODE_FALLEN) begin
        mw_n    = 1'b1;
        pcmd_n  = brs_pkg::PCMD_OFF;
        mode_n  = brs_pkg::MODE_FALLEN;
        phase_n = 4'd0;
      end
    end else begin
      miss_n = 8'd0;
    end

    case (mode_n)
      brs_pkg::MODE_WAIT: begin
        if (phase_n == 4'd0) begin
          beep_n  = 1'b1;
          blen_n  = brs_pkg::BEEP_LONG;
          phase_n = 4'd1;
        end
        if (btn) begin
          mode_n  = brs_pkg::MODE_CALIB;
          start_n = clock_ms;
          phase_n = 4'd0;
          mark_n  = clock_ms - TIME_BITS'(brs_pkg::CALIB_BEEP_GAP);
          cb_n    = 1'b1;
        end
      end
      brs_pkg::MODE_CALIB: begin
        if (phase_n < brs_pkg::PHASE_CALIB_END &&
            since_mark >= TIME_BITS'(brs_pkg::CALIB_BEEP_GAP)) begin
          beep_n  = 1'b1;
          blen_n  = brs_pkg::BEEP_LONG;
          mark_n  = clock_ms;
          phase_n = phase_n + 4'd1;
        end
        if (btn) begin
          mode_n  = brs_pkg::MODE_WAIT;
          phase_n = 4'd0;
          miss_n  = 8'd0;
        end else if (!busy) begin
          cc_n    = 1'b1;
          mode_n  = brs_pkg::MODE_READY;
          phase_n = 4'd0;
          mark_n  = clock_ms;
        end else if (since_start > TIME_BITS'(calib_limit)) begin
          mode_n  = brs_pkg::MODE_FALLEN;
          phase_n = brs_pkg::PHASE_ERROR;
          mark_n  = clock_ms;
          pat_n   = 10'd0;
        end
      end
      brs_pkg::MODE_READY: begin
        if (phase_n == 4'd0) begin
          beep_n  = 1'b1;
          blen_n  = brs_pkg::BEEP_LONG;
          mark_n  = clock_ms;
          phase_n = 4'd1;
        end else if (phase_n == 4'd1 &&
                     since_mark >= TIME_BITS'(brs_pkg::READY_GAP_1)) begin
          beep_n  = 1'b1;
          blen_n  = brs_pkg::BEEP_LONG;
          mark_n  = clock_ms;
          phase_n = 4'd2;
        end else if (phase_n == 4'd2 &&
                     since_mark >= TIME_BITS'(brs_pkg::READY_GAP_2)) begin
          mode_n = brs_pkg::MODE_BALANCE;
        end
      end
      brs_pkg::MODE_BALANCE: begin
        if (got) begin
          mw_n = 1'b1;
          if (tilt_out) begin
            pcmd_n  = brs_pkg::PCMD_OFF;
            mode_n  = brs_pkg::MODE_FALLEN;
            phase_n = 4'd0;
          end else begin
            pcmd_n  = brs_pkg::PCMD_RUN;
            speed_n = map_speed;
          end
        end
      end
      default: begin
        if (phase_n == brs_pkg::PHASE_ERROR &&
            (pat_n == brs_pkg::PAT_BEEP_0 || pat_n == brs_pkg::PAT_BEEP_1 ||
             pat_n == brs_pkg::PAT_BEEP_2)) begin
          beep_n = 1'b1;
          blen_n = brs_pkg::BEEP_SHORT;
        end
        if (btn) begin
          mode_n  = brs_pkg::MODE_WAIT;
          phase_n = 4'd0;
          miss_n  = 8'd0;
        end
      end
    endcase
  end

  // supervisor state: clocks advance at accept, the rest at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode     <= brs_pkg::MODE_WAIT;
      clock_ms         <= '0;
      mode_start_ms    <= '0;
      beep_mark_ms     <= '0;
      beep_phase       <= 4'd0;
      missed_count     <= 8'd0;
      error_pattern_ms <= 10'd0;
    end else if (cmd.load) begin
      clock_ms <= clock_ms + TIME_BITS'(tick_ms);
      if (pat_sum >= brs_pkg::PAT_PERIOD) begin
        error_pattern_ms <= 10'(pat_sum - brs_pkg::PAT_PERIOD);
      end else begin
        error_pattern_ms <= pat_sum[9:0];
      end
    end else if (cmd.commit) begin
      current_mode     <= mode_n;
      mode_start_ms    <= start_n;
      beep_mark_ms     <= mark_n;
      beep_phase       <= phase_n;
      missed_count     <= miss_n;
      error_pattern_ms <= pat_n;
    end
  end

  // input latch and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      got     <= in_data[0];
      btn     <= in_data[1];
      busy    <= in_data[2];
      tilt    <= $signed(in_data[18:3]);
      pid     <= $signed(in_data[42:19]);
      divisor <= (in_data[42] ? 24'(-in_data[42:19]) : in_data[42:19])
                 + brs_pkg::MAP_OFFSET;
      rem     <= '0;
      quo     <= brs_pkg::MAP_NUMER;
    end else if (cmd.step) begin
      rem <= rem_ge ? 24'(rem_sh - {1'b0, divisor}) : rem_sh[23:0];
      quo <= {quo[brs_pkg::DIV_BITS-2:0], rem_ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_mode  <= mode_n;
      o_mw    <= mw_n;
      o_speed <= speed_n;
      o_pcmd  <= pcmd_n;
      o_beep  <= beep_n;
      o_blen  <= blen_n;
      o_cb    <= cb_n;
      o_cc    <= cc_n;
    end
  end

  assign m_tdata = {4'b0000, o_cc, o_cb, o_blen, o_beep, o_pcmd, o_speed, o_mw, o_mode};

  // pattern counter stays inside its period
  a_pat_range: assert property (@(posedge clk) disable iff (rst)
    error_pattern_ms < 10'd1000)
    else $error("pattern counter out of range");

  // a result is only loaded when the register is free
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result overwritten");

  // nonzero speed only comes with a pid run command
  a_speed_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_speed != 11'sd0) |-> (o_mw && o_pcmd == brs_pkg::PCMD_RUN))
    else $error("speed without pid run");

  // a beep length goes only with a beep request
  a_beep_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_beep == (o_blen != 8'd0)))
    else $error("beep length mismatch");

  // input latch, divider step and commit never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.step, cmd.commit}) <= 1)
    else $error("overlapping commands");

endmodule

// ===== design/balance_robot_supervisor.sv =====
`timescale 1ns / 1ps
// balance robot supervisor top level: streaming ports, config port
// depends on brs_pkg, brs_ctrl and brs_datapath
//
// Usage:
//   One input beat is one control tick. The beat carries the sample flag,
//   button event, calibration busy flag, tilt angle and pid output. Each
//   tick yields exactly one result beat with the mode after the tick, motor
//   and pid commands, buzzer request and calibration strobes.
//   A 29-step restoring divider for the motor speed mapping runs after the
//   input beat is taken; the tick then commits to the output register.
//   One tick is in flight at a time: no beat is accepted before the commit.
//   A finished result waits in an output register; if the receiver stalls,
//   the next tick is still accepted and computed, then holds until the
//   register is taken.
//   Config registers (tilt limit, calibration timeout, missing limit, tick
//   length) are written through cfg_we/cfg_addr/cfg_data at any edge and
//   are meant to change only while the block is idle.
//   Reset (rst, synchronous) puts the supervisor in wait mode, clears the
//   clock, timers and counters, restores register defaults, drops m_tvalid.
module balance_robot_supervisor #(
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // sample_valid, button_pressed, calib_busy, tilt_angle[15:0], pid_result[23:0]
  input  logic [brs_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // mode[2:0], motor_write, motor_speed[10:0], pid_command[1:0], beep_request,
  // beep_length[7:0], calib_begin, calib_commit
  output logic [brs_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [brs_pkg::CFG_W-1:0] cfg_data
);

  brs_pkg::cmd_t  cmd;
  brs_pkg::stat_t stat;

  // sequencing
  brs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // supervisor datapath
  brs_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for balance_robot_supervisor: directed ticks, then scripted
// robot sessions with random content under several register settings and stall mixes
// depends on brs_pkg and the balance_robot_supervisor top level
module testbench;

  localparam int TIME_W = 32;
  localparam int END_WAIT = 40;

  // one control tick as packed into s_tdata
  typedef struct packed {
    logic signed [23:0] pid_result;
    logic signed [15:0] tilt_angle;
    logic               calib_busy;
    logic               button_pressed;
    logic               sample_valid;
  } tick_item_t;

  // one supervisor decision
  typedef struct packed {
    logic [2:0]         mode;
    logic               motor_write;
    logic signed [10:0] motor_speed;
    logic [1:0]         pid_command;
    logic               beep_request;
    logic [7:0]         beep_length;
    logic               calib_begin;
    logic               calib_commit;
  } tick_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic [brs_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [brs_pkg::OUT_W-1:0] m_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_addr = '0;
  logic [brs_pkg::CFG_W-1:0] cfg_data = '0;

  balance_robot_supervisor #(.TIME_BITS(TIME_W)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // stimulus and scoreboard storage
  tick_item_t   tick_q[$];
  tick_result_t decision_q[$];
  int           n_pushed = 0;
  int           n_taken = 0;
  int           err_count = 0;
  int           src_idle = 0;
  int           sink_idle = 0;
  logic         s_took = 1'b0;

  // shadow registers
  logic [14:0] lim_tilt = brs_pkg::TILT_LIMIT_RST;
  logic [15:0] lim_calib = brs_pkg::CALIB_TIMEOUT_RST;
  logic [7:0]  lim_missing = brs_pkg::MISSING_LIMIT_RST;
  logic [7:0]  ms_per_tick = brs_pkg::TICK_MS_RST;

  // shadow supervisor state
  logic [2:0]        sv_mode = brs_pkg::MODE_WAIT;
  logic [TIME_W-1:0] sv_clock = '0;
  logic [TIME_W-1:0] sv_mode_mark = '0;
  logic [TIME_W-1:0] sv_beep_mark = '0;
  logic [3:0]        sv_beep_step = '0;
  logic [7:0]        sv_missed = '0;
  logic [10:0]       sv_pattern = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] elapsed(logic [TIME_W-1:0] mark);
    return sv_clock - mark;
  endfunction

  // 400 - (405 - 5500/(|p|+9)) with p and the inner term in q8, truncated toward zero, sign of p restored
  function automatic logic signed [10:0] stepper_speed(logic signed [23:0] p);
    longint m, d, x, c, ci, sp;
    if (p == 0) begin
      return '0;
    end
    m = (p < 0) ? -longint'(p) : longint'(p);
    d = m + longint'(brs_pkg::MAP_OFFSET);
    x = longint'(brs_pkg::MAP_NUMER) / d;
    c = longint'(brs_pkg::MAP_BASE) - x;
    ci = c / 256;
    sp = longint'(brs_pkg::SPEED_TOP) - ci;
    if (p < 0) begin
      sp = -sp;
    end
    return sp[10:0];
  endfunction

  // advance the shadow supervisor by one tick
  function automatic tick_result_t predict_tick(tick_item_t it);
    tick_result_t r;
    int tilt_v, lim_v;
    r = '0;
    sv_clock = sv_clock + ms_per_tick;
    sv_pattern = sv_pattern + ms_per_tick;
    if (sv_pattern >= brs_pkg::PAT_PERIOD) begin
      sv_pattern = sv_pattern - brs_pkg::PAT_PERIOD;
    end
    // missed-sample watchdog
    if (!it.sample_valid) begin
      if (sv_missed != 8'd255) begin
        sv_missed = sv_missed + 8'd1;
      end
      if (sv_missed >= lim_missing && sv_mode != brs_pkg::MODE_FALLEN) begin
        r.motor_write = 1'b1;
        r.pid_command = brs_pkg::PCMD_OFF;
        sv_mode = brs_pkg::MODE_FALLEN;
        sv_beep_step = '0;
      end
    end else begin
      sv_missed = '0;
    end
    case (sv_mode)
      brs_pkg::MODE_WAIT: begin
        if (sv_beep_step == 4'd0) begin
          r.beep_request = 1'b1;
          r.beep_length = brs_pkg::BEEP_LONG;
          sv_beep_step = 4'd1;
        end
        if (it.button_pressed) begin
          sv_mode = brs_pkg::MODE_CALIB;
          sv_mode_mark = sv_clock;
          sv_beep_step = '0;
          sv_beep_mark = sv_clock - brs_pkg::CALIB_BEEP_GAP;
          r.calib_begin = 1'b1;
        end
      end
      brs_pkg::MODE_CALIB: begin
        if (sv_beep_step < brs_pkg::PHASE_CALIB_END &&
            elapsed(sv_beep_mark) >= brs_pkg::CALIB_BEEP_GAP) begin
          r.beep_request = 1'b1;
          r.beep_length = brs_pkg::BEEP_LONG;
          sv_beep_mark = sv_clock;
          sv_beep_step = sv_beep_step + 4'd1;
        end
        if (it.button_pressed) begin
          sv_mode = brs_pkg::MODE_WAIT;
          sv_beep_step = '0;
          sv_missed = '0;
        end else if (!it.calib_busy) begin
          r.calib_commit = 1'b1;
          sv_mode = brs_pkg::MODE_READY;
          sv_beep_step = '0;
          sv_beep_mark = sv_clock;
        end else if (elapsed(sv_mode_mark) > lim_calib) begin
          sv_mode = brs_pkg::MODE_FALLEN;
          sv_beep_step = brs_pkg::PHASE_ERROR;
          sv_beep_mark = sv_clock;
          sv_pattern = '0;
        end
      end
      brs_pkg::MODE_READY: begin
        if (sv_beep_step == 4'd0) begin
          r.beep_request = 1'b1;
          r.beep_length = brs_pkg::BEEP_LONG;
          sv_beep_mark = sv_clock;
          sv_beep_step = 4'd1;
        end else if (sv_beep_step == 4'd1 &&
                     elapsed(sv_beep_mark) >= brs_pkg::READY_GAP_1) begin
          r.beep_request = 1'b1;
          r.beep_length = brs_pkg::BEEP_LONG;
          sv_beep_mark = sv_clock;
          sv_beep_step = 4'd2;
        end else if (sv_beep_step == 4'd2 &&
                     elapsed(sv_beep_mark) >= brs_pkg::READY_GAP_2) begin
          sv_mode = brs_pkg::MODE_BALANCE;
        end
      end
      brs_pkg::MODE_BALANCE: begin
        if (it.sample_valid) begin
          tilt_v = it.tilt_angle;
          lim_v = lim_tilt;
          r.motor_write = 1'b1;
          if (tilt_v > lim_v || tilt_v < -lim_v) begin
            r.pid_command = brs_pkg::PCMD_OFF;
            sv_mode = brs_pkg::MODE_FALLEN;
            sv_beep_step = '0;
          end else begin
            r.pid_command = brs_pkg::PCMD_RUN;
            r.motor_speed = stepper_speed(it.pid_result);
          end
        end
      end
      default: begin
        // error code: three short beeps at the start of each second
        if (sv_beep_step == brs_pkg::PHASE_ERROR && (sv_pattern == brs_pkg::PAT_BEEP_0 ||
            sv_pattern == brs_pkg::PAT_BEEP_1 || sv_pattern == brs_pkg::PAT_BEEP_2)) begin
          r.beep_request = 1'b1;
          r.beep_length = brs_pkg::BEEP_SHORT;
        end
        if (it.button_pressed) begin
          sv_mode = brs_pkg::MODE_WAIT;
          sv_beep_step = '0;
          sv_missed = '0;
        end
      end
    endcase
    r.mode = sv_mode;
    return r;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic check_decision(tick_result_t want, logic [brs_pkg::OUT_W-1:0] got);
    compare_field("mode", want.mode, got[2:0]);
    compare_field("motor_write", want.motor_write, got[3]);
    compare_field("motor_speed", want.motor_speed, $signed(got[14:4]));
    compare_field("pid_command", want.pid_command, got[16:15]);
    compare_field("beep_request", want.beep_request, got[17]);
    compare_field("beep_length", want.beep_length, got[25:18]);
    compare_field("calib_begin", want.calib_begin, got[26]);
    compare_field("calib_commit", want.calib_commit, got[27]);
  endtask

  // input driver: next beat once the current one is taken; random output ready
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || s_took) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
          s_tdata <= brs_pkg::IN_W'(tick_q.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  // monitor: predict on each accepted tick, check each result beat
  always @(posedge clk) begin
    s_took = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        s_took = 1'b1;
        n_taken++;
        decision_q.push_back(predict_tick(tick_item_t'(s_tdata[42:0])));
      end
      if (m_tvalid && m_tready) begin
        if (decision_q.size() == 0) begin
          $error("result beat with no tick pending: %h", m_tdata);
          err_count++;
        end else begin
          check_decision(decision_q.pop_front(), m_tdata);
        end
      end
    end
  end

  task automatic push_tick(bit sv, bit btn, bit busy, int tilt, int pid);
    tick_item_t it;
    it.sample_valid = sv;
    it.button_pressed = btn;
    it.calib_busy = busy;
    it.tilt_angle = tilt[15:0];
    it.pid_result = pid[23:0];
    tick_q.push_back(it);
    n_pushed++;
  endtask

  function automatic int rand_pid();
    int v;
    if ($urandom_range(0, 1) == 1) begin
      v = $urandom_range(0, 4000);
      return v - 2000;
    end
    return $urandom();
  endfunction

  function automatic int tilt_upright();
    int v, lim;
    lim = lim_tilt;
    v = $urandom_range(0, 2 * lim);
    return v - lim;
  endfunction

  function automatic int tilt_over();
    int v, lim;
    lim = lim_tilt;
    if (lim < 32767 && $urandom_range(0, 1) == 1) begin
      v = $urandom_range(lim + 1, 32767);
    end else begin
      v = $urandom_range(lim + 1, 32768);
      v = -v;
    end
    return v;
  endfunction

  function automatic bit coin();
    return $urandom_range(0, 1);
  endfunction

  // one robot session: wait, calibrate, ready, balance, fall, back to wait; or a noise burst
  task automatic run_session();
    int n, tt;
    if ($urandom_range(0, 9) == 0) begin
      // noise burst
      n = $urandom_range(5, 20);
      repeat (n) push_tick($urandom_range(0, 3) != 0, $urandom_range(0, 6) == 0, coin(),
                           $urandom(), $urandom());
      return;
    end
    n = $urandom_range(0, 3);
    repeat (n) push_tick(1'b1, 1'b0, coin(), tilt_upright(), rand_pid());
    push_tick(1'b1, 1'b1, 1'b0, tilt_upright(), rand_pid());
    // calibration, sometimes long enough to time out
    tt = (ms_per_tick != 0) ? lim_calib / ms_per_tick + 2 : 5;
    if (tt > 300) begin
      tt = 300;
    end
    n = ($urandom_range(0, 4) == 0) ? tt : $urandom_range(0, 6);
    repeat (n) push_tick($urandom_range(0, 19) != 0, $urandom_range(0, 29) == 0, 1'b1,
                         tilt_upright(), rand_pid());
    push_tick(1'b1, 1'b0, 1'b0, tilt_upright(), rand_pid());
    // ready beeps
    n = (ms_per_tick != 0) ? 700 / ms_per_tick + $urandom_range(0, 3) : $urandom_range(2, 6);
    if (n > 400) begin
      n = 400;
    end
    repeat (n) push_tick(1'b1, 1'b0, coin(), tilt_upright(), rand_pid());
    // balancing
    n = $urandom_range(5, 40);
    repeat (n) push_tick($urandom_range(0, 19) != 0, 1'b0, coin(),
                         ($urandom_range(0, 6) == 0) ? int'($urandom()) : tilt_upright(),
                         rand_pid());
    // fall by tilt or by lost samples
    if (coin()) begin
      push_tick(1'b1, 1'b0, coin(), tilt_over(), rand_pid());
    end else begin
      n = lim_missing + $urandom_range(0, 3);
      repeat (n) push_tick(1'b0, 1'b0, coin(), $urandom(), rand_pid());
    end
    n = $urandom_range(0, 5);
    repeat (n) push_tick(coin(), 1'b0, coin(), tilt_upright(), rand_pid());
    push_tick(1'b1, 1'b1, 1'b0, tilt_upright(), rand_pid());
  endtask

  // returns at a falling edge once every tick has its result back
  task automatic wait_drained();
    do @(negedge clk); while (n_taken != n_pushed || decision_q.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value[brs_pkg::CFG_W-1:0];
    @(negedge clk);
  endtask

  task automatic apply_setting(int tilt, int timeout, int missing, int tick);
    write_reg(brs_pkg::CFG_TILT_LIMIT, tilt);
    write_reg(brs_pkg::CFG_CALIB_TIMEOUT, timeout);
    write_reg(brs_pkg::CFG_MISSING_LIMIT, missing);
    write_reg(brs_pkg::CFG_TICK_MS, tick);
    cfg_we <= 1'b0;
    lim_tilt = tilt[14:0];
    lim_calib = timeout[15:0];
    lim_missing = missing[7:0];
    ms_per_tick = tick[7:0];
  endtask

  task automatic run_phase(int tilt, int timeout, int missing, int tick,
                           int src, int sink, int budget);
    int start;
    wait_drained();
    apply_setting(tilt, timeout, missing, tick);
    @(posedge clk);
    src_idle = src;
    sink_idle = sink;
    start = n_pushed;
    while (n_pushed - start < budget) begin
      run_session();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle = 38;
    sink_idle = 76;
    // reset defaults: wait beep, calibration start, cancel by button
    push_tick(1'b1, 1'b0, 1'b0, 0, 0);
    push_tick(1'b1, 1'b1, 1'b0, 0, 0);
    push_tick(1'b1, 1'b0, 1'b1, 0, 0);
    push_tick(1'b1, 1'b1, 1'b1, 0, 0);
    // zero limits, long ticks: forced fall, timeout, full walk to balance
    wait_drained();
    apply_setting(0, 0, 0, 255);
    @(posedge clk);
    push_tick(1'b0, 1'b0, 1'b0, 0, 0);
    push_tick(1'b1, 1'b1, 1'b0, 0, 0);
    push_tick(1'b1, 1'b0, 1'b0, 0, 0);
    push_tick(1'b1, 1'b1, 1'b0, 0, 0);
    push_tick(1'b1, 1'b0, 1'b1, 0, 0);
    push_tick(1'b1, 1'b1, 1'b0, 0, 0);
    push_tick(1'b1, 1'b1, 1'b0, 0, 0);
    push_tick(1'b1, 1'b0, 1'b0, 0, 0);
    repeat (4) push_tick(1'b1, 1'b0, 1'b0, 0, 0);
    push_tick(1'b1, 1'b0, 1'b0, 0, 0);
    push_tick(1'b1, 1'b0, 1'b0, 0, 8388607);
    push_tick(1'b1, 1'b0, 1'b0, 0, -8388608);
    push_tick(1'b1, 1'b0, 1'b0, 0, 1);
    push_tick(1'b1, 1'b0, 1'b0, 0, -1);
    push_tick(1'b1, 1'b0, 1'b0, 1, 0);
    // random sessions under several settings and stall mixes
    run_phase(brs_pkg::TILT_LIMIT_RST, brs_pkg::CALIB_TIMEOUT_RST,
              brs_pkg::MISSING_LIMIT_RST, brs_pkg::TICK_MS_RST, 38, 76, 200);
    run_phase(32767, 65535, 255, 255, 38, 76, 200);
    run_phase(0, 0, 1, 100, 76, 38, 200);
    run_phase($urandom_range(0, 32767), $urandom_range(0, 3000), $urandom_range(1, 40),
              $urandom_range(5, 255), 76, 38, 200);
    run_phase(1, 1000, 3, 50, 0, 0, 200);
    run_phase($urandom_range(0, 32767), $urandom_range(0, 65535), $urandom_range(1, 255),
              $urandom_range(1, 255), 0, 0, 200);
    run_phase(200, 500, 0, 0, 0, 0, 60);
    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/brs_pkg.sv
design/brs_ctrl.sv
design/brs_datapath.sv
design/balance_robot_supervisor.sv
tb/testbench.sv
